// ===== rtl/led_frame_receiver_top_assert.svh =====
// Assertion macros used by the LED frame receiver queue.
`ifndef LED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define LED_FRAME_RECEIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked on clk, masked while rst_n is low.
`define LFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// Clocked on clk, checked through reset as well.
`define LFR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);
`else
`define LFR_ASSERT(lbl, prop, msg)
`define LFR_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/lfr_pkg.sv =====
// Types and constants of the LED frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package lfr_pkg;

  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_TYPE  = 3'd0;
  localparam logic [POS_W-1:0] POS_ADDR  = 3'd1;
  localparam logic [POS_W-1:0] POS_VAL0  = 3'd2;
  localparam logic [POS_W-1:0] POS_VAL1  = 3'd3;
  localparam logic [POS_W-1:0] POS_VAL2  = 3'd4;
  localparam logic [POS_W-1:0] POS_VAL3  = 3'd5;
  localparam logic [POS_W-1:0] POS_CHECK = 3'd6;
  localparam logic [POS_W-1:0] POS_SPARE = 3'd7;

  localparam logic [7:0] FRAME_TYPE_PIXEL = 8'hFF;
  localparam logic [7:0] ADDR_ALL    = 8'hFF;
  localparam logic [7:0] ADDR_COLUMN = 8'h90;
  localparam int unsigned LED_COUNT  = 128;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic        checksum_ok;
    logic        pixel_frame;
    logic [7:0]  frame_type;
    logic [7:0]  target_code;
    logic [31:0] payload_value;
    logic [63:0] led_mask_low;
    logic [63:0] led_mask_high;
  } out_item_t;

  // Completed frame handed from the front to the back.
  typedef struct packed {
    logic        checksum_ok;
    logic [7:0]  frame_type;
    logic [7:0]  target_code;
    logic [31:0] payload_value;
  } frame_rec_t;

endpackage
`default_nettype wire

// ===== rtl/lfr_front.sv =====
// Front end: tracks byte position, running sum and fields, emits finished frames.
`timescale 1ns / 1ps
`default_nettype none
module lfr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire lfr_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   in_full,
  output logic                   q_push,
  output lfr_pkg::frame_rec_t    q_data
);
  import lfr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]       sum_r, sum_nxt, sum_add;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [31:0]      val_r, val_nxt;
  logic             accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign sum_add = sum_r + in_data.rx_byte;

  always_comb begin
    pos_cur = in_data.frame_start ? POS_TYPE : pos_r;
    if (pos_cur == POS_SPARE) begin
      pos_cur = POS_TYPE;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    type_nxt = type_r;
    addr_nxt = addr_r;
    val_nxt  = val_r;
    if (accept) begin
      unique case (pos_cur)
        POS_TYPE: begin
          sum_nxt  = in_data.rx_byte;
          type_nxt = in_data.rx_byte;
          addr_nxt = '0;
          val_nxt  = '0;
          pos_nxt  = POS_ADDR;
        end
        POS_ADDR: begin
          sum_nxt  = sum_add;
          addr_nxt = in_data.rx_byte;
          pos_nxt  = POS_VAL0;
        end
        POS_VAL0: begin
          sum_nxt       = sum_add;
          val_nxt[7:0]  = val_r[7:0] | in_data.rx_byte;
          pos_nxt       = POS_VAL1;
        end
        POS_VAL1: begin
          sum_nxt        = sum_add;
          val_nxt[15:8]  = val_r[15:8] | in_data.rx_byte;
          pos_nxt        = POS_VAL2;
        end
        POS_VAL2: begin
          sum_nxt        = sum_add;
          val_nxt[23:16] = val_r[23:16] | in_data.rx_byte;
          pos_nxt        = POS_VAL3;
        end
        POS_VAL3: begin
          sum_nxt        = sum_add;
          val_nxt[31:24] = val_r[31:24] | in_data.rx_byte;
          pos_nxt        = POS_CHECK;
        end
        POS_CHECK: begin
          pos_nxt = POS_TYPE;
        end
        default: begin
          pos_nxt = POS_TYPE;
        end
      endcase
    end
  end

  // Checksum byte matches when it brings the 8-bit sum to zero.
  assign q_push              = accept && (pos_cur == POS_CHECK);
  assign q_data.checksum_ok  = (sum_add == 8'd0);
  assign q_data.frame_type   = type_r;
  assign q_data.target_code  = addr_r;
  assign q_data.payload_value = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_TYPE;
      sum_r  <= '0;
      type_r <= '0;
      addr_r <= '0;
      val_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      type_r <= type_nxt;
      addr_r <= addr_nxt;
      val_r  <= val_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lfr_queue.sv =====
// Two-entry queue of finished frames between front and back.
`timescale 1ns / 1ps
`default_nettype none
module lfr_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire lfr_pkg::frame_rec_t push_data,
  input  wire logic                pop,
  output logic                     full,
  output logic                     valid,
  output lfr_pkg::frame_rec_t      head
);
  import lfr_pkg::*;

  frame_rec_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`include "led_frame_receiver_top_assert.svh"
  `LFR_ASSERT(a_no_push_full, push |-> !full, "frame queue pushed while full")
  `LFR_ASSERT(a_no_pop_empty, pop |-> valid, "frame queue popped while empty")
  `LFR_ASSERT(a_ptr_match, (cnt_r != 2'd1) |-> (wr_ptr_r == rd_ptr_r), "queue pointer mismatch")
  `LFR_ASSERT(a_cnt_range, cnt_r != 2'd3, "frame queue count out of range")
  `LFR_ASSERT_RST(a_reset_empty, !rst_n |=> (cnt_r == 2'd0), "frame queue not empty after reset")

endmodule
`default_nettype wire

// ===== rtl/lfr_back.sv =====
// Back end: decodes the LED mask and holds the result register.
`timescale 1ns / 1ps
`default_nettype none
module lfr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire lfr_pkg::frame_rec_t q_head,
  output logic                     q_pop,
  input  wire logic                out_pop,
  output logic                     out_empty,
  output lfr_pkg::out_item_t       out_data
);
  import lfr_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r;
  out_item_t            res;
  logic [LED_COUNT-1:0] mask;
  logic [7:0]           a;

  assign a = q_head.target_code;

  always_comb begin
    mask = '0;
    if (a == ADDR_ALL) begin
      mask = '1;
    end else if ((a & ADDR_COLUMN) == ADDR_COLUMN) begin
      // one LED in each block of sixteen
      for (int i = 0; i < 8; i++) begin
        mask[{3'(i), a[3:0]}] = 1'b1;
      end
    end else if (a[7]) begin
      for (int i = 0; i < 16; i++) begin
        mask[{a[6:4], 4'(i)}] = 1'b1;
      end
    end else begin
      mask[a[6:0]] = 1'b1;
    end
  end

  always_comb begin
    res.checksum_ok   = q_head.checksum_ok;
    res.pixel_frame   = (q_head.frame_type == FRAME_TYPE_PIXEL);
    res.frame_type    = q_head.frame_type;
    res.target_code   = q_head.target_code;
    res.payload_value = q_head.payload_value;
    res.led_mask_low  = mask[63:0];
    res.led_mask_high = mask[127:64];
  end

  // Load when the result register is free or being drained this cycle.
  assign q_pop = q_valid && (!out_valid_r || out_pop);
  assign out_valid_nxt = q_pop || (out_valid_r && !out_pop);
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/led_frame_receiver_top.sv =====
// Top level of the LED frame receiver.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------
//   input    | in_push/in_full  | in_data   (rx_byte, frame_start)
//   result   | out_pop/out_empty| out_data  (flags, fields, mask)
//
// One byte is taken every cycle while the frame queue has room.
// The seventh byte of a frame is written into the two-entry queue at the edge
// that takes it; the LED mask is then decoded from the queue head into the result
// register when that register is free or is being drained.
// rst_n is synchronous; it clears position, sum, fields, queue and result valid flag.
// in_full rises only when both queue slots and the result register are held
// by a stalled consumer.
`timescale 1ns / 1ps
`default_nettype none
module led_frame_receiver_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire lfr_pkg::in_item_t  in_data,
  output logic                    in_full,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output lfr_pkg::out_item_t      out_data
);
  import lfr_pkg::*;

  logic       q_push, q_full, q_valid, q_pop;
  frame_rec_t q_in, q_head;

  lfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .in_full (in_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  lfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  lfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
